// ===== hdl/cftp_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN frame text parser package
// Shared types, constants and the per-character scan functions.
// ----------------------------------------------------------------------------
package cftp_pkg;

    localparam int unsigned ACC_W     = 32;
    localparam int unsigned ID_W      = 11;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NUM_BYTES = 8;

    localparam logic [ACC_W-1:0]   ID_MAX     = 32'h0000_07ff;
    localparam logic [ACC_W-1:0]   BYTE_MAX   = 32'h0000_00ff;
    localparam logic [COUNT_W-1:0] LAST_SLOT  = 4'd7;
    localparam logic [7:0]         SPACE_MAX  = 8'd32;

    typedef enum logic [2:0] {
        PH_GAP  = 3'd0,
        PH_DEC  = 3'd1,
        PH_ZERO = 3'd2,
        PH_HEX  = 3'd3,
        PH_BIN  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ID_BIG   = 3'd1,
        ST_TOO_MANY = 3'd2,
        ST_BYTE_BIG = 3'd3,
        ST_NO_ID    = 3'd4
    } status_t;

    typedef struct packed {
        phase_t                              phase;
        logic [ACC_W-1:0]                    acc;
        logic                                id_seen;
        logic [ID_W-1:0]                     held_id;
        logic [COUNT_W-1:0]                  held_count;
        logic [NUM_BYTES-1:0][BYTE_W-1:0]    held_bytes;
        status_t                             err;
        logic                                stopped;
    } scan_state_t;

    typedef struct packed {
        status_t                             status;
        logic [ID_W-1:0]                     frame_id;
        logic [COUNT_W-1:0]                  byte_count;
        logic [NUM_BYTES-1:0][BYTE_W-1:0]    data;
    } result_t;

    localparam scan_state_t SCAN_RESET = '0;

    // Close the current number: first one is the ID, the rest are data bytes.
    function automatic scan_state_t take_number(scan_state_t s, logic [ACC_W-1:0] n);
        s.phase = PH_GAP;
        s.acc   = '0;
        if (!s.id_seen) begin
            if (n > ID_MAX) begin
                s.err     = ST_ID_BIG;
                s.stopped = 1'b1;
            end
            else begin
                s.held_id = n[ID_W-1:0];
                s.id_seen = 1'b1;
            end
        end
        else if (s.held_count > LAST_SLOT) begin
            s.err     = ST_TOO_MANY;
            s.stopped = 1'b1;
        end
        else if (n > BYTE_MAX) begin
            s.err     = ST_BYTE_BIG;
            s.stopped = 1'b1;
        end
        else begin
            s.held_bytes[s.held_count[2:0]] = n[BYTE_W-1:0];
            s.held_count = s.held_count + 4'd1;
        end
        return s;
    endfunction

    function automatic scan_state_t start_token(scan_state_t s, logic [7:0] c);
        if (c == 8'd0) begin
            s.stopped = 1'b1;
        end
        else if (c <= SPACE_MAX) begin
            s.phase = PH_GAP;
        end
        else if (c == "0") begin
            s.phase = PH_ZERO;
            s.acc   = '0;
        end
        else if (c >= "1" && c <= "9") begin
            s.phase = PH_DEC;
            s.acc   = {{(ACC_W-4){1'b0}}, c[3:0]};
        end
        else begin
            s.stopped = 1'b1;
        end
        return s;
    endfunction

    function automatic scan_state_t scan_char(scan_state_t s, logic [7:0] c);
        logic             is_dec;
        logic             is_hex_uc;
        logic             is_hex_lc;
        logic [ACC_W-1:0] times_ten;
        is_dec    = (c >= "0" && c <= "9");
        is_hex_uc = (c >= "A" && c <= "F");
        is_hex_lc = (c >= "a" && c <= "f");
        // acc * 10 + digit as a shift-add
        times_ten = (s.acc << 3) + (s.acc << 1) + {{(ACC_W-4){1'b0}}, c[3:0]};
        unique case (s.phase)
            PH_ZERO: begin
                if (c == "x" || c == "X") begin
                    s.phase = PH_HEX;
                    s.acc   = '0;
                end
                else if (c == "b" || c == "B") begin
                    s.phase = PH_BIN;
                    s.acc   = '0;
                end
                else if (is_dec) begin
                    s.phase = PH_DEC;
                    s.acc   = times_ten;
                end
                else begin
                    s = take_number(s, s.acc);
                    if (!s.stopped) s = start_token(s, c);
                end
            end
            PH_DEC: begin
                if (is_dec) begin
                    s.acc = times_ten;
                end
                else begin
                    s = take_number(s, s.acc);
                    if (!s.stopped) s = start_token(s, c);
                end
            end
            PH_HEX: begin
                if (is_dec) begin
                    s.acc = {s.acc[ACC_W-5:0], c[3:0]};
                end
                else if (is_hex_uc || is_hex_lc) begin
                    // 'A'/'a' low nibble is 1, so nibble + 9 gives 10..15
                    s.acc = {s.acc[ACC_W-5:0], c[3:0] + 4'd9};
                end
                else begin
                    s = take_number(s, s.acc);
                    if (!s.stopped) s = start_token(s, c);
                end
            end
            PH_BIN: begin
                if (c == "0" || c == "1") begin
                    s.acc = {s.acc[ACC_W-2:0], c[0]};
                end
                else begin
                    s = take_number(s, s.acc);
                    if (!s.stopped) s = start_token(s, c);
                end
            end
            default: begin
                s = start_token(s, c);
            end
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/cftp_in_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one text character per transaction.
// ----------------------------------------------------------------------------
interface cftp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== hdl/cftp_out_if.sv =====
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one parsed frame per transaction.
// ----------------------------------------------------------------------------
interface cftp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [10:0] frame_id;
    logic [3:0]  byte_count;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [7:0]  data_6;
    logic [7:0]  data_7;

    modport source (
        output valid, output status, output frame_id, output byte_count,
        output data_0, output data_1, output data_2, output data_3,
        output data_4, output data_5, output data_6, output data_7,
        input  ready
    );
    modport sink (
        input  valid, input status, input frame_id, input byte_count,
        input  data_0, input data_1, input data_2, input data_3,
        input  data_4, input data_5, input data_6, input data_7,
        output ready
    );
endinterface

// ===== hdl/cftp_scan.sv =====
// ----------------------------------------------------------------------------
// CAN frame text scanner
// Holds the parse state and advances it by one character per step.
// ----------------------------------------------------------------------------
module cftp_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        character,
    input  logic              last_char,
    output cftp_pkg::result_t result
);

    cftp_pkg::scan_state_t state_reg;
    cftp_pkg::scan_state_t state_next;
    cftp_pkg::scan_state_t scanned;
    cftp_pkg::scan_state_t closed;
    cftp_pkg::status_t     status;

    always_comb
    begin
        scanned = state_reg;
        if (!state_reg.stopped) scanned = cftp_pkg::scan_char(state_reg, character);

        // a number still open at the end of the text is closed here
        closed = scanned;
        if (!scanned.stopped && scanned.phase != cftp_pkg::PH_GAP)
            closed = cftp_pkg::take_number(scanned, scanned.acc);

        if (closed.err != cftp_pkg::ST_OK)
            status = closed.err;
        else if (!closed.id_seen)
            status = cftp_pkg::ST_NO_ID;
        else
            status = cftp_pkg::ST_OK;

        result = '0;
        result.status = status;
        if (status == cftp_pkg::ST_OK) begin
            result.frame_id   = closed.held_id;
            result.byte_count = closed.held_count;
            // slots past the count are never written, so they stay zero
            result.data       = closed.held_bytes;
        end

        state_next = state_reg;
        if (step) state_next = last_char ? cftp_pkg::SCAN_RESET : scanned;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cftp_pkg::SCAN_RESET;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/can_frame_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// CAN frame text parser
// Parses send-frame command text into an identifier and up to eight bytes.
// ----------------------------------------------------------------------------
// Takes one character per transaction and delivers one frame result per
// command, on the transaction after the character flagged last_char. Throughput
// is one character per clock unless a stalled result holds up input; the parse
// state advances by one character per step, the decimal accumulate being a
// shift-add. A character is held in the input register before it is parsed,
// and the frame is loaded into the output register as that last character
// steps the parser, so frame.valid rises from the output register once the
// last character has passed through the input register. A stalled result
// holds up input only once the next command's last character is waiting in
// the input register.
module can_frame_text_parser_top (
    input logic       clk,
    input logic       rst_n,
    cftp_in_if.sink   text,
    cftp_out_if.source frame
);

    logic              in_vld_reg;
    logic [7:0]        char_reg;
    logic              last_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic              advance;
    logic              step;
    cftp_pkg::result_t result;
    cftp_pkg::result_t res_reg;

    // only a last character needs room in the output register
    assign advance    = !out_vld_reg || frame.ready;
    assign step       = in_vld_reg && (advance || !last_reg);
    assign text.ready = !in_vld_reg || step;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance) out_vld_next = step && last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else begin
            if (text.ready) in_vld_reg <= text.valid;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid) begin
            char_reg <= text.character;
            last_reg <= text.last_char;
        end
        if (step && last_reg) res_reg <= result;
    end

    cftp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .character (char_reg),
        .last_char (last_reg),
        .result    (result)
    );

    assign frame.valid      = out_vld_reg;
    assign frame.status     = res_reg.status;
    assign frame.frame_id   = res_reg.frame_id;
    assign frame.byte_count = res_reg.byte_count;
    assign frame.data_0     = res_reg.data[0];
    assign frame.data_1     = res_reg.data[1];
    assign frame.data_2     = res_reg.data[2];
    assign frame.data_3     = res_reg.data[3];
    assign frame.data_4     = res_reg.data[4];
    assign frame.data_5     = res_reg.data[5];
    assign frame.data_6     = res_reg.data[6];
    assign frame.data_7     = res_reg.data[7];

endmodule
